@@ rtl/psf_pkg.sv @@
// Package for the scanline span fill block: payload structs, vertex and
// crossing records, state machine encodings and fixed-point constants.
// No dependencies.
`default_nettype none

package psf_pkg;

    // Fixed widths of the coordinate formats, plus limits and step counts
    localparam int COORD_W   = 16;
    localparam int ROW_W     = 12;
    localparam int FRAC_BITS = 4;
    localparam int MIN_VERTS = 3;
    localparam int MAX_SPANS = 8;
    localparam int SPAN_W    = 4;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int DIV_STEPS = COORD_W;
    localparam int STEP_W    = 5;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_ROW  = 1'b1
    } op_t;

    typedef struct packed {
        logic                      op;
        logic                      restart;
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic signed [ROW_W-1:0]   row_y;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] span_left;
        logic signed [COORD_W-1:0] span_right;
        logic signed [ROW_W-1:0]   span_row;
        logic                      span_valid;
        logic                      last_span;
        logic                      overflow;
    } out_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } vertex_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x1;
        logic signed [COORD_W-1:0] y1;
        logic signed [COORD_W-1:0] x2;
        logic signed [COORD_W-1:0] y2;
        logic signed [COORD_W-1:0] fy;
    } edge_req_t;

    typedef struct packed {
        logic                      hit;
        logic signed [COORD_W-1:0] x;
    } edge_rsp_t;

    typedef enum logic [1:0] {
        E_IDLE,
        E_MUL,
        E_DSTART,
        E_DIV
    } edge_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIRST,
        S_FETCH,
        S_NEXTV,
        S_EDGE,
        S_WAIT,
        S_INS_RD,
        S_INS_CMP,
        S_ADV,
        S_SETUP,
        S_EMPTY,
        S_RDL,
        S_RDR,
        S_RDW,
        S_PUT
    } main_state_t;

endpackage

`default_nettype wire

@@ rtl/psf_div.sv @@
// Restoring divider, one quotient bit per cycle, for the crossing offset.
// Depends on psf_pkg for the fixed operand widths.
`default_nettype none

module psf_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [psf_pkg::PROD_W-1:0]      dividend,
    input  wire logic [psf_pkg::COORD_W-1:0]     divisor,
    output logic                                 done,
    output logic [psf_pkg::COORD_W-1:0]          quotient
);

    localparam int CW = psf_pkg::COORD_W;
    localparam int SW = psf_pkg::STEP_W;

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [SW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] rem_reg, rem_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] den_reg, den_next;
    logic [CW:0]   trial;
    logic [CW:0]   diff;
    logic          ge;

    // Operand load on start, then a trial subtract of the shifted remainder per step
    always_comb
    begin
        trial     = {rem_reg, lo_reg[CW-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = (trial >= {1'b0, den_reg});
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        den_next  = den_reg;
        if (start)
        begin
            // Quotient is known to fit CW bits, so the upper half seeds the remainder
            rem_next = dividend[2*CW-1:CW];
            lo_next  = dividend[CW-1:0];
            den_next = divisor;
            cnt_next = SW'(psf_pkg::DIV_STEPS);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next = ge ? diff[CW-1:0] : trial[CW-1:0];
            lo_next  = {lo_reg[CW-2:0], ge};
            cnt_next = cnt_reg - SW'(1);
            if (cnt_reg == SW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        den_reg <= den_next;
    end

    assign done     = done_reg;
    assign quotient = lo_reg;

endmodule

`default_nettype wire

@@ rtl/psf_edge.sv @@
// Edge crossing unit: orders the ends, applies the half-open row test and
// interpolates x with one multiply and an iterative divide.
// Depends on psf_pkg and psf_div.
`default_nettype none

module psf_edge (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire psf_pkg::edge_req_t req,
    output logic                    done,
    output psf_pkg::edge_rsp_t      rsp
);

    localparam int CW = psf_pkg::COORD_W;
    localparam int PW = psf_pkg::PROD_W;

    psf_pkg::edge_state_t state_reg, state_next;
    logic                 done_reg, done_next;
    logic                 hit_reg, hit_next;
    logic                 neg_reg, neg_next;
    logic [CW-1:0]        dy_reg, dy_next;
    logic [CW-1:0]        dxm_reg, dxm_next;
    logic [CW-1:0]        den_reg, den_next;
    logic signed [CW-1:0] x1_reg, x1_next;
    logic signed [CW-1:0] x_reg, x_next;
    logic [PW-1:0]        prod_reg, prod_next;

    logic signed [CW-1:0] lx, ly, hx, hy;
    logic signed [CW:0]   dx;
    logic signed [CW:0]   dyw;
    logic signed [CW:0]   denw;
    logic signed [CW:0]   qs;
    logic signed [CW:0]   xs;
    logic                 hit;
    logic                 div_start;
    logic                 div_done;
    logic [CW-1:0]        quo;

    psf_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (quo)
    );

    // Order the ends, test the row and sequence multiply then divide
    always_comb
    begin
        if (req.y1 > req.y2)
        begin
            lx = req.x2; ly = req.y2; hx = req.x1; hy = req.y1;
        end
        else
        begin
            lx = req.x1; ly = req.y1; hx = req.x2; hy = req.y2;
        end
        hit  = (req.fy >= ly) && (req.fy < hy);
        dx   = {hx[CW-1], hx} - {lx[CW-1], lx};
        dyw  = {req.fy[CW-1], req.fy} - {ly[CW-1], ly};
        denw = {hy[CW-1], hy} - {ly[CW-1], ly};
        qs   = neg_reg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        xs   = {x1_reg[CW-1], x1_reg} + qs;

        state_next = state_reg;
        done_next  = 1'b0;
        hit_next   = hit_reg;
        neg_next   = neg_reg;
        dy_next    = dy_reg;
        dxm_next   = dxm_reg;
        den_next   = den_reg;
        x1_next    = x1_reg;
        x_next     = x_reg;
        prod_next  = prod_reg;
        div_start  = 1'b0;
        case (state_reg)
            psf_pkg::E_IDLE:
            begin
                if (start)
                begin
                    hit_next = hit;
                    dy_next  = dyw[CW-1:0];
                    den_next = denw[CW-1:0];
                    neg_next = dx[CW];
                    dxm_next = dx[CW] ? CW'(-dx) : dx[CW-1:0];
                    x1_next  = lx;
                    if (hit)
                        state_next = psf_pkg::E_MUL;
                    else
                        done_next = 1'b1;
                end
            end
            psf_pkg::E_MUL:
            begin
                prod_next  = dy_reg * dxm_reg;
                state_next = psf_pkg::E_DSTART;
            end
            psf_pkg::E_DSTART:
            begin
                div_start  = 1'b1;
                state_next = psf_pkg::E_DIV;
            end
            psf_pkg::E_DIV:
            begin
                if (div_done)
                begin
                    x_next     = xs[CW-1:0];
                    done_next  = 1'b1;
                    state_next = psf_pkg::E_IDLE;
                end
            end
            default:
                state_next = psf_pkg::E_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psf_pkg::E_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg  <= hit_next;
        neg_reg  <= neg_next;
        dy_reg   <= dy_next;
        dxm_reg  <= dxm_next;
        den_reg  <= den_next;
        x1_reg   <= x1_next;
        x_reg    <= x_next;
        prod_reg <= prod_next;
    end

    assign done    = done_reg;
    assign rsp.hit = hit_reg;
    assign rsp.x   = x_reg;

endmodule

`default_nettype wire

@@ rtl/polygon_scanline_span_fill.sv @@
// Scanline polygon span fill, even-odd rule, signed Q12.4 coordinates.
// Request channel (req_valid/req_stall/req): a load transfer appends one
// vertex to the vertex memory (restart clears the polygon first); vertices
// beyond MAX_VERTICES are dropped and raise the overflow flag. A row transfer
// walks every closed edge, interpolates the crossings, insertion-sorts them
// into the crossing memory and sends one span per pair on the result channel
// (rsp_valid/rsp_stall/rsp), at most eight, with last_span on the final one.
// A row with no spans gives one result with span_valid clear.
// A load is written straight from idle. A row fetches each vertex, starts
// the edge unit on each edge and advances; a crossing edge adds one multiply
// and a 16-step divide, each crossing is placed by sorted insertion that
// shifts larger entries up one place at a time, and each span sent is read
// from the crossing memory as its left and right ends. The divider and each
// memory's single port set the row time. req_stall is high while a row is
// in progress. The result register lets the next request in while a finished
// result waits; a stalled receiver holds the row walk at its next result.
// Reset clears the vertex count and overflow flag and empties the result
// register; memory contents are not cleared.
// Depends on psf_pkg, psf_edge and psf_div.
`default_nettype none

module polygon_scanline_span_fill #(
    parameter int MAX_VERTICES = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire psf_pkg::in_item_t  req,
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output psf_pkg::out_item_t      rsp
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW = $clog2(MAX_VERTICES + 1);
    localparam int CW = psf_pkg::COORD_W;
    localparam int SW = psf_pkg::SPAN_W;
    localparam int FB = psf_pkg::FRAC_BITS;

    // Memories
    psf_pkg::vertex_t     vmem [MAX_VERTICES];
    logic [CW-1:0]        xmem [MAX_VERTICES];
    psf_pkg::vertex_t     vrd_reg;
    logic signed [CW-1:0] xrd_reg;

    logic                 v_we, v_re, x_we, x_re;
    logic [AW-1:0]        v_waddr, v_raddr, x_waddr, x_raddr;
    psf_pkg::vertex_t     v_wdata;
    logic [CW-1:0]        x_wdata;

    psf_pkg::main_state_t state_reg, state_next;
    logic [NW-1:0]        count_reg, count_next;
    logic                 dropped_reg, dropped_next;
    logic [NW-1:0]        i_reg, i_next;
    logic [NW-1:0]        nx_reg, nx_next;
    logic [NW-1:0]        j_reg, j_next;
    logic [SW-1:0]        k_reg, k_next;
    logic [SW-1:0]        nsp_reg, nsp_next;
    logic                 outv_reg, outv_next;
    psf_pkg::out_item_t   out_reg, out_next;
    logic signed [psf_pkg::ROW_W-1:0] row_reg, row_next;
    logic signed [CW-1:0] ins_reg, ins_next;
    logic signed [CW-1:0] left_reg, left_next;
    logic signed [CW-1:0] right_reg, right_next;
    psf_pkg::vertex_t     first_reg, first_next;
    psf_pkg::vertex_t     cur_reg, cur_next;
    psf_pkg::vertex_t     nxt_reg, nxt_next;

    logic                 edge_start;
    logic                 edge_done;
    psf_pkg::edge_req_t   edge_req;
    psf_pkg::edge_rsp_t   edge_rsp;

    logic                 out_free;
    logic [NW-1:0]        base;
    logic [NW-1:0]        i_inc;
    logic [NW-1:0]        half;
    logic [SW:0]          k2;

    psf_edge u_edge (
        .clk   (clk),
        .rst_n (rst_n),
        .start (edge_start),
        .req   (edge_req),
        .done  (edge_done),
        .rsp   (edge_rsp)
    );

    assign edge_req.x1 = cur_reg.x;
    assign edge_req.y1 = cur_reg.y;
    assign edge_req.x2 = nxt_reg.x;
    assign edge_req.y2 = nxt_reg.y;
    assign edge_req.fy = CW'({row_reg, {FB{1'b0}}});

    // Vertex memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (v_we)
            vmem[v_waddr] <= v_wdata;
        if (v_re)
            vrd_reg <= vmem[v_raddr];
    end

    // Crossing memory, kept sorted ascending
    always_ff @(posedge clk)
    begin
        if (x_we)
            xmem[x_waddr] <= x_wdata;
        if (x_re)
            xrd_reg <= xmem[x_raddr];
    end

    // Sequence loads, the edge walk, sorted insertion and span output
    always_comb
    begin
        out_free  = !outv_reg || !rsp_stall;
        base      = req.restart ? '0 : count_reg;
        i_inc     = i_reg + NW'(1);
        half      = nx_reg >> 1;
        k2        = {k_reg, 1'b0};

        state_next   = state_reg;
        count_next   = count_reg;
        dropped_next = dropped_reg;
        i_next       = i_reg;
        nx_next      = nx_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        nsp_next     = nsp_reg;
        outv_next    = outv_reg && rsp_stall;
        out_next     = out_reg;
        row_next     = row_reg;
        ins_next     = ins_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        first_next   = first_reg;
        cur_next     = cur_reg;
        nxt_next     = nxt_reg;
        edge_start   = 1'b0;
        v_we         = 1'b0;
        v_waddr      = base[AW-1:0];
        v_wdata.x    = req.vertex_x;
        v_wdata.y    = req.vertex_y;
        v_re         = 1'b0;
        v_raddr      = '0;
        x_we         = 1'b0;
        x_waddr      = j_reg[AW-1:0];
        x_wdata      = ins_reg;
        x_re         = 1'b0;
        x_raddr      = '0;
        req_stall    = 1'b1;

        case (state_reg)
            psf_pkg::S_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    if (req.op == psf_pkg::OP_LOAD)
                    begin
                        if (req.restart)
                            dropped_next = 1'b0;
                        if (32'(base) < MAX_VERTICES)
                        begin
                            v_we       = 1'b1;
                            count_next = base + NW'(1);
                        end
                        else
                            dropped_next = 1'b1;
                    end
                    else
                    begin
                        row_next = req.row_y;
                        nx_next  = '0;
                        i_next   = '0;
                        if (32'(count_reg) < psf_pkg::MIN_VERTS)
                            state_next = psf_pkg::S_SETUP;
                        else
                        begin
                            v_re       = 1'b1;
                            v_raddr    = '0;
                            state_next = psf_pkg::S_FIRST;
                        end
                    end
                end
            end
            psf_pkg::S_FIRST:
            begin
                first_next = vrd_reg;
                cur_next   = vrd_reg;
                state_next = psf_pkg::S_FETCH;
            end
            psf_pkg::S_FETCH:
            begin
                // Next vertex, or close the polygon back to the first
                if (i_inc < count_reg)
                begin
                    v_re       = 1'b1;
                    v_raddr    = i_inc[AW-1:0];
                    state_next = psf_pkg::S_NEXTV;
                end
                else
                begin
                    nxt_next   = first_reg;
                    state_next = psf_pkg::S_EDGE;
                end
            end
            psf_pkg::S_NEXTV:
            begin
                nxt_next   = vrd_reg;
                state_next = psf_pkg::S_EDGE;
            end
            psf_pkg::S_EDGE:
            begin
                edge_start = 1'b1;
                state_next = psf_pkg::S_WAIT;
            end
            psf_pkg::S_WAIT:
            begin
                if (edge_done)
                begin
                    if (edge_rsp.hit)
                    begin
                        ins_next   = edge_rsp.x;
                        j_next     = nx_reg;
                        state_next = psf_pkg::S_INS_RD;
                    end
                    else
                        state_next = psf_pkg::S_ADV;
                end
            end
            psf_pkg::S_INS_RD:
            begin
                if (j_reg == '0)
                begin
                    x_we       = 1'b1;
                    nx_next    = nx_reg + NW'(1);
                    state_next = psf_pkg::S_ADV;
                end
                else
                begin
                    x_re       = 1'b1;
                    x_raddr    = AW'(j_reg - NW'(1));
                    state_next = psf_pkg::S_INS_CMP;
                end
            end
            psf_pkg::S_INS_CMP:
            begin
                // Shift the larger entry up one place, or drop the new one in
                x_we = 1'b1;
                if (xrd_reg > ins_reg)
                begin
                    x_wdata    = xrd_reg;
                    j_next     = j_reg - NW'(1);
                    state_next = psf_pkg::S_INS_RD;
                end
                else
                begin
                    nx_next    = nx_reg + NW'(1);
                    state_next = psf_pkg::S_ADV;
                end
            end
            psf_pkg::S_ADV:
            begin
                cur_next = nxt_reg;
                i_next   = i_inc;
                if (i_inc >= count_reg)
                    state_next = psf_pkg::S_SETUP;
                else
                    state_next = psf_pkg::S_FETCH;
            end
            psf_pkg::S_SETUP:
            begin
                k_next = '0;
                if (32'(half) > psf_pkg::MAX_SPANS)
                    nsp_next = SW'(psf_pkg::MAX_SPANS);
                else
                    nsp_next = SW'(half);
                if (half == '0)
                    state_next = psf_pkg::S_EMPTY;
                else
                    state_next = psf_pkg::S_RDL;
            end
            psf_pkg::S_EMPTY:
            begin
                if (out_free)
                begin
                    outv_next           = 1'b1;
                    out_next.span_left  = '0;
                    out_next.span_right = '0;
                    out_next.span_row   = row_reg;
                    out_next.span_valid = 1'b0;
                    out_next.last_span  = 1'b1;
                    out_next.overflow   = dropped_reg;
                    state_next          = psf_pkg::S_IDLE;
                end
            end
            psf_pkg::S_RDL:
            begin
                x_re       = 1'b1;
                x_raddr    = AW'(k2);
                state_next = psf_pkg::S_RDR;
            end
            psf_pkg::S_RDR:
            begin
                left_next  = xrd_reg;
                x_re       = 1'b1;
                x_raddr    = AW'(k2 + (SW+1)'(1));
                state_next = psf_pkg::S_RDW;
            end
            psf_pkg::S_RDW:
            begin
                right_next = xrd_reg;
                state_next = psf_pkg::S_PUT;
            end
            psf_pkg::S_PUT:
            begin
                // Hold here while the result register is still occupied
                if (out_free)
                begin
                    outv_next           = 1'b1;
                    out_next.span_left  = left_reg;
                    out_next.span_right = right_reg;
                    out_next.span_row   = row_reg;
                    out_next.span_valid = 1'b1;
                    out_next.last_span  = (k_reg + SW'(1) == nsp_reg);
                    out_next.overflow   = dropped_reg;
                    k_next              = k_reg + SW'(1);
                    if (k_reg + SW'(1) == nsp_reg)
                        state_next = psf_pkg::S_IDLE;
                    else
                        state_next = psf_pkg::S_RDL;
                end
            end
            default:
                state_next = psf_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= psf_pkg::S_IDLE;
            count_reg   <= '0;
            dropped_reg <= 1'b0;
            outv_reg    <= 1'b0;
            i_reg       <= '0;
            nx_reg      <= '0;
            j_reg       <= '0;
            k_reg       <= '0;
            nsp_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
            outv_reg    <= outv_next;
            i_reg       <= i_next;
            nx_reg      <= nx_next;
            j_reg       <= j_next;
            k_reg       <= k_next;
            nsp_reg     <= nsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg   <= out_next;
        row_reg   <= row_next;
        ins_reg   <= ins_next;
        left_reg  <= left_next;
        right_reg <= right_next;
        first_reg <= first_next;
        cur_reg   <= cur_next;
        nxt_reg   <= nxt_next;
    end

    assign rsp_valid = outv_reg;
    assign rsp       = out_reg;

endmodule

`default_nettype wire
